@@ src/dllm_pkg.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list manager package
// Shared widths, request codes, internal operation kinds and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dllm_pkg;

  // Default size of the node pool.
  localparam int NODES_DEF = 256;

  // Fixed field widths of the request and result words.
  localparam int OP_W      = 3;
  localparam int NODE_W    = 8;
  localparam int CNT_OUT_W = 9;

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_INS_FIRST  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_LAST   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

  // Effective operation after null-anchor and range resolution.
  typedef enum logic [2:0] {
    K_NONE,
    K_FIRST,
    K_LAST,
    K_AFTER,
    K_BEFORE,
    K_DELETE
  } kind_t;

  // Request sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK1,
    ST_LINK2,
    ST_HOLD
  } state_t;

endpackage

@@ src/dllm_link_ram.sv @@
// ----------------------------------------------------------------------------
// Link table memory
// One-write, one-read synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dllm_link_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/doubly_linked_list_manager.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Keeps a doubly linked list over a pool of node numbers in two link memories
// and reports head, tail and count after every insert or delete request.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                         Direction
//   -------   -------------------------------------------   ---------
//   request   in_valid/in_ready, op, node, anchor, null     in
//   result    out_valid/out_ready, head, tail, count        out
//
// The accept state issues the link read, the first link state does at most
// one write to each memory, and the second link state does any remaining
// writes and updates head, tail and count; each link memory has a single
// write port. The result word is registered from the updated head, tail and
// count once the output register is free, and no new request is taken until
// the sequencer is back in idle. Reset clears head, tail, count and the
// handshake state; the link memories are not cleared. A stalled result holds
// the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doubly_linked_list_manager #(
  parameter int NODES = dllm_pkg::NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dllm_pkg::OP_W-1:0]      in_op,
  input  logic [dllm_pkg::NODE_W-1:0]    in_node,
  input  logic [dllm_pkg::NODE_W-1:0]    in_anchor,
  input  logic                           in_anchor_null,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dllm_pkg::NODE_W-1:0]    out_head_node,
  output logic                           out_head_valid,
  output logic [dllm_pkg::NODE_W-1:0]    out_tail_node,
  output logic                           out_tail_valid,
  output logic [dllm_pkg::CNT_OUT_W-1:0] out_entry_count
);

  import dllm_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int XW = IW + NODE_W;

  // A link is {valid, index}; a cleared valid bit means null.
  localparam logic [LW-1:0] LINK_NIL = '0;

  state_t          state_r, state_nxt;
  kind_t           kind_r, kind_in;
  logic [IW-1:0]   node_r, anchor_r;
  logic [LW-1:0]   head_r, head_nxt;
  logic [LW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r;
  logic [NODE_W-1:0]    out_head_r, out_tail_r;
  logic                 out_hv_r, out_tv_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic            in_fire, out_free, out_load;
  logic [XW-1:0]   node_ext, anchor_ext;
  logic [IW-1:0]   node_idx, anchor_idx;
  logic            node_ok, anchor_ok;

  logic            nx_we, pv_we, rd_en;
  logic [IW-1:0]   nx_wa, pv_wa, rd_addr;
  logic [LW-1:0]   nx_wd, pv_wd, nx_rd, pv_rd;
  logic [LW-1:0]   mk_node, mk_anchor;

  logic [XW-1:0]        head_ext, tail_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  // Handshake.
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ((state_r == ST_LINK2) || (state_r == ST_HOLD)) && out_free;

  // Node numbers resized to the pool index width, with range checks.
  assign node_ext   = {{IW{1'b0}}, in_node};
  assign anchor_ext = {{IW{1'b0}}, in_anchor};
  assign node_idx   = node_ext[IW-1:0];
  assign anchor_idx = anchor_ext[IW-1:0];
  assign node_ok    = node_ext < XW'(NODES);
  assign anchor_ok  = anchor_ext < XW'(NODES);

  // Resolve the request into one effective operation.
  always_comb begin
    kind_in = K_NONE;
    if (node_ok) begin
      unique case (in_op)
        OP_INS_FIRST:  kind_in = K_FIRST;
        OP_INS_LAST:   kind_in = K_LAST;
        OP_INS_AFTER: begin
          if (in_anchor_null) kind_in = K_FIRST;
          else if (anchor_ok) kind_in = K_AFTER;
        end
        OP_INS_BEFORE: begin
          if (in_anchor_null) kind_in = K_LAST;
          else if (anchor_ok) kind_in = K_BEFORE;
        end
        OP_DELETE:     kind_in = K_DELETE;
        default:       kind_in = K_NONE;
      endcase
    end
  end

  // The link read is issued in the accept cycle: the anchor's entry for
  // inserts, the node's own entry for delete.
  assign rd_en   = in_fire && ((kind_in == K_AFTER) || (kind_in == K_BEFORE) ||
                               (kind_in == K_DELETE));
  assign rd_addr = (kind_in == K_DELETE) ? node_idx : anchor_idx;

  // Request capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_NONE;
    end else if (in_fire) begin
      kind_r <= kind_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      node_r   <= node_idx;
      anchor_r <= anchor_idx;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_LINK1;
      ST_LINK1: state_nxt = ST_LINK2;
      ST_LINK2: state_nxt = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign mk_node   = {1'b1, node_r};
  assign mk_anchor = {1'b1, anchor_r};

  // Link memory writes. Each memory gets at most two writes per request,
  // issued in the same order as the list update defines them.
  always_comb begin
    nx_we = 1'b0;
    nx_wa = node_r;
    nx_wd = LINK_NIL;
    pv_we = 1'b0;
    pv_wa = node_r;
    pv_wd = LINK_NIL;
    unique case (state_r)
      ST_LINK1: begin
        unique case (kind_r)
          K_FIRST: begin
            nx_we = 1'b1;
            nx_wd = head_r;
            pv_we = 1'b1;
            pv_wd = LINK_NIL;
          end
          K_LAST: begin
            nx_we = 1'b1;
            nx_wd = LINK_NIL;
            pv_we = 1'b1;
            pv_wd = tail_r;
          end
          K_AFTER: begin
            pv_we = nx_rd[IW];
            pv_wa = nx_rd[IW-1:0];
            pv_wd = mk_node;
            nx_we = 1'b1;
            nx_wd = nx_rd;
          end
          K_BEFORE: begin
            nx_we = pv_rd[IW];
            nx_wa = pv_rd[IW-1:0];
            nx_wd = mk_node;
            pv_we = 1'b1;
            pv_wd = pv_rd;
          end
          K_DELETE: begin
            nx_we = pv_rd[IW];
            nx_wa = pv_rd[IW-1:0];
            nx_wd = nx_rd;
            pv_we = nx_rd[IW];
            pv_wa = nx_rd[IW-1:0];
            pv_wd = pv_rd;
          end
          default: begin
          end
        endcase
      end
      ST_LINK2: begin
        unique case (kind_r)
          K_FIRST: begin
            pv_we = head_r[IW];
            pv_wa = head_r[IW-1:0];
            pv_wd = mk_node;
          end
          K_LAST: begin
            nx_we = tail_r[IW];
            nx_wa = tail_r[IW-1:0];
            nx_wd = mk_node;
          end
          K_AFTER: begin
            pv_we = 1'b1;
            pv_wd = mk_anchor;
            nx_we = 1'b1;
            nx_wa = anchor_r;
            nx_wd = mk_node;
          end
          K_BEFORE: begin
            nx_we = 1'b1;
            nx_wd = mk_anchor;
            pv_we = 1'b1;
            pv_wa = anchor_r;
            pv_wd = mk_node;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Head, tail and count update in the second link cycle.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (state_r == ST_LINK2) begin
      unique case (kind_r)
        K_FIRST: begin
          if (!head_r[IW]) tail_nxt = mk_node;
          head_nxt = mk_node;
        end
        K_LAST: begin
          if (!tail_r[IW]) head_nxt = mk_node;
          tail_nxt = mk_node;
        end
        K_AFTER: begin
          if (!nx_rd[IW]) tail_nxt = mk_node;
        end
        K_BEFORE: begin
          if (!pv_rd[IW]) head_nxt = mk_node;
        end
        K_DELETE: begin
          if (!pv_rd[IW]) head_nxt = nx_rd;
          if (!nx_rd[IW]) tail_nxt = pv_rd;
        end
        default: begin
        end
      endcase
      // Count saturates at the pool size and at zero.
      if ((kind_r == K_FIRST) || (kind_r == K_LAST) ||
          (kind_r == K_AFTER) || (kind_r == K_BEFORE)) begin
        if (cnt_r < CW'(NODES)) cnt_nxt = cnt_r + CW'(1);
      end else if (kind_r == K_DELETE) begin
        if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= LINK_NIL;
      tail_r <= LINK_NIL;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Result word, taken from the updated pointers.
  assign head_ext = {{NODE_W{1'b0}}, head_nxt[IW-1:0]};
  assign tail_ext = {{NODE_W{1'b0}}, tail_nxt[IW-1:0]};
  assign cnt_ext  = {{CNT_OUT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hv_r   <= head_nxt[IW];
      out_tv_r   <= tail_nxt[IW];
      out_head_r <= head_nxt[IW] ? head_ext[NODE_W-1:0] : '0;
      out_tail_r <= tail_nxt[IW] ? tail_ext[NODE_W-1:0] : '0;
      out_cnt_r  <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_head_node   = out_head_r;
  assign out_head_valid  = out_hv_r;
  assign out_tail_node   = out_tail_r;
  assign out_tail_valid  = out_tv_r;
  assign out_entry_count = out_cnt_r;

  // Next and previous link memories.
  dllm_link_ram #(
    .DEPTH (NODES),
    .WIDTH (LW),
    .AW    (IW)
  ) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_wa),
    .wdata (nx_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (nx_rd)
  );

  dllm_link_ram #(
    .DEPTH (NODES),
    .WIDTH (LW),
    .AW    (IW)
  ) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_wa),
    .wdata (pv_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pv_rd)
  );

endmodule

@@ src/dllm_checker.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list manager port checker
// Watches the result port for consistent head, tail and count words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dllm_checker #(
  parameter int NODES = dllm_pkg::NODES_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [dllm_pkg::NODE_W-1:0]    out_head_node,
  input logic                           out_head_valid,
  input logic [dllm_pkg::NODE_W-1:0]    out_tail_node,
  input logic                           out_tail_valid,
  input logic [dllm_pkg::CNT_OUT_W-1:0] out_entry_count
);

  import dllm_pkg::*;

  // An empty head reads as node zero.
  a_head_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_head_valid) |-> (out_head_node == '0))
    else $error("head node not zero while head is null");

  // An empty tail reads as node zero.
  a_tail_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tail_valid) |-> (out_tail_node == '0))
    else $error("tail node not zero while tail is null");

  // The count never passes the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_entry_count) <= NODES))
    else $error("entry count above pool size");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_head_node) &&
      $stable(out_tail_node) && $stable(out_entry_count)))
    else $error("result word changed while stalled");

endmodule

bind doubly_linked_list_manager dllm_checker #(
  .NODES (NODES)
) u_dllm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_head_node   (out_head_node),
  .out_head_valid  (out_head_valid),
  .out_tail_node   (out_tail_node),
  .out_tail_valid  (out_tail_valid),
  .out_entry_count (out_entry_count)
);

@@ dv/doubly_linked_list_checker.sv @@
// ----------------------------------------------------------------------------
// Linked list result checker
// Watches the request and result channels of the list manager, keeps its own
// copy of the link tables, head, tail and count, and compares every result
// word with the summary predicted for the oldest request still in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doubly_linked_list_checker #(
  parameter int NODES = dllm_pkg::NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [dllm_pkg::OP_W-1:0]      in_op,
  input  logic [dllm_pkg::NODE_W-1:0]    in_node,
  input  logic [dllm_pkg::NODE_W-1:0]    in_anchor,
  input  logic                           in_anchor_null,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [dllm_pkg::NODE_W-1:0]    out_head_node,
  input  logic                           out_head_valid,
  input  logic [dllm_pkg::NODE_W-1:0]    out_tail_node,
  input  logic                           out_tail_valid,
  input  logic [dllm_pkg::CNT_OUT_W-1:0] out_entry_count,
  output int                             fail_count,
  output int                             outstanding
);

  import dllm_pkg::*;

  // A link is a node number plus a valid bit; a cleared valid bit is null.
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] idx;
  } link_t;

  typedef struct packed {
    logic [NODE_W-1:0]    head_node;
    logic                 head_valid;
    logic [NODE_W-1:0]    tail_node;
    logic                 tail_valid;
    logic [CNT_OUT_W-1:0] entry_count;
  } list_summary_t;

  localparam link_t NO_LINK = '0;

  link_t         fwd_link [NODES];
  link_t         back_link[NODES];
  link_t         first_ptr;
  link_t         last_ptr;
  int unsigned   node_total;
  list_summary_t predicted_summaries[$];

  function automatic link_t link_to(input int unsigned n);
    link_t l;
    l.valid = 1'b1;
    l.idx   = NODE_W'(n);
    return l;
  endfunction

  // The count saturates at the pool size.
  function automatic void count_up();
    if (node_total < NODES) node_total++;
  endfunction

  // Applies one request to the shadow list and returns the summary the block
  // must report for it. Table writes follow the block's fixed order, so
  // wrongly named nodes land the same way as in hardware.
  function automatic list_summary_t predict_summary(input logic [OP_W-1:0]   op,
                                                    input logic [NODE_W-1:0] node,
                                                    input logic [NODE_W-1:0] anchor,
                                                    input logic              anull);
    kind_t         kind;
    link_t         p;
    link_t         x;
    list_summary_t s;
    kind = K_NONE;
    if (node < NODES) begin
      case (op)
        OP_INS_FIRST:  kind = K_FIRST;
        OP_INS_LAST:   kind = K_LAST;
        // A null anchor turns insert-after into insert-first.
        OP_INS_AFTER:  kind = anull ? K_FIRST : ((anchor < NODES) ? K_AFTER : K_NONE);
        // A null anchor turns insert-before into insert-last.
        OP_INS_BEFORE: kind = anull ? K_LAST : ((anchor < NODES) ? K_BEFORE : K_NONE);
        OP_DELETE:     kind = K_DELETE;
        default:       kind = K_NONE;
      endcase
    end

    case (kind)
      K_FIRST: begin
        fwd_link[node]  = first_ptr;
        back_link[node] = NO_LINK;
        if (first_ptr.valid) back_link[first_ptr.idx] = link_to(node);
        else last_ptr = link_to(node);
        first_ptr = link_to(node);
        count_up();
      end
      K_LAST: begin
        fwd_link[node]  = NO_LINK;
        back_link[node] = last_ptr;
        if (last_ptr.valid) fwd_link[last_ptr.idx] = link_to(node);
        else first_ptr = link_to(node);
        last_ptr = link_to(node);
        count_up();
      end
      K_AFTER: begin
        x = fwd_link[anchor];
        if (x.valid) back_link[x.idx] = link_to(node);
        else last_ptr = link_to(node);
        back_link[node] = link_to(anchor);
        fwd_link[node]  = x;
        fwd_link[anchor] = link_to(node);
        count_up();
      end
      K_BEFORE: begin
        p = back_link[anchor];
        if (p.valid) fwd_link[p.idx] = link_to(node);
        else first_ptr = link_to(node);
        fwd_link[node]  = link_to(anchor);
        back_link[node] = p;
        back_link[anchor] = link_to(node);
        count_up();
      end
      K_DELETE: begin
        p = back_link[node];
        x = fwd_link[node];
        if (p.valid) fwd_link[p.idx] = x;
        else first_ptr = x;
        if (x.valid) back_link[x.idx] = p;
        else last_ptr = p;
        if (node_total > 0) node_total--;
      end
      default: ;
    endcase

    // Node fields read as zero when their pointer is null.
    s.head_node   = first_ptr.valid ? first_ptr.idx : '0;
    s.head_valid  = first_ptr.valid;
    s.tail_node   = last_ptr.valid ? last_ptr.idx : '0;
    s.tail_valid  = last_ptr.valid;
    s.entry_count = CNT_OUT_W'(node_total);
    return s;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Results are matched before new requests are predicted, so a word taken
  // in the same cycle as a request always pairs with an older request.
  always @(posedge clk) begin
    list_summary_t want;
    if (!rst_n) begin
      first_ptr  = NO_LINK;
      last_ptr   = NO_LINK;
      node_total = 0;
      predicted_summaries.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_summaries.size() == 0) begin
          $display("%0t: result word with no request pending: head %0d/%0d tail %0d/%0d count %0d",
                   $time, out_head_node, out_head_valid, out_tail_node, out_tail_valid,
                   out_entry_count);
          fail_count++;
        end else begin
          want = predicted_summaries.pop_front();
          compare_field("head_node", want.head_node, out_head_node);
          compare_field("head_valid", want.head_valid, out_head_valid);
          compare_field("tail_node", want.tail_node, out_tail_node);
          compare_field("tail_valid", want.tail_valid, out_tail_valid);
          compare_field("entry_count", want.entry_count, out_entry_count);
        end
      end
      if (in_valid && in_ready) begin
        predicted_summaries.push_back(predict_summary(in_op, in_node, in_anchor,
                                                      in_anchor_null));
      end
    end
    outstanding = predicted_summaries.size();
  end

endmodule

@@ dv/doubly_linked_list_manager_test.sv @@
// ----------------------------------------------------------------------------
// Doubly linked list manager test
// Drives directed and random insert and delete requests with random idling
// on both channels and one long result stall, and reports the verdict from
// the checker's failure count once every predicted result has arrived.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doubly_linked_list_manager_test;
  import dllm_pkg::*;

  localparam int POOL         = NODES_DEF;
  localparam int RANDOM_WORDS = 1100;
  localparam int CALM_WORDS   = 150;
  localparam int LONG_HOLD    = 150;

  // Codes the block must ignore.
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_W'(OP_DELETE + 1);
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_op          = '0;
  logic [NODE_W-1:0]    in_node        = '0;
  logic [NODE_W-1:0]    in_anchor      = '0;
  logic                 in_anchor_null = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [NODE_W-1:0]    out_head_node;
  logic                 out_head_valid;
  logic [NODE_W-1:0]    out_tail_node;
  logic                 out_tail_valid;
  logic [CNT_OUT_W-1:0] out_entry_count;
  int                   fail_count;
  int                   outstanding;

  // Idling control shared by both channel processes.
  bit idle_on;
  bit hold_req;

  // Stimulus view of the list: which nodes should be linked, and which have
  // ever been inserted (only those have link entries that may be read).
  bit on_list[POOL];
  bit seen[POOL];
  int listed;
  int seen_total;

  always #4 clk = ~clk;

  doubly_linked_list_manager #(.NODES(POOL)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_node(in_node), .in_anchor(in_anchor),
    .in_anchor_null(in_anchor_null),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_head_node(out_head_node), .out_head_valid(out_head_valid),
    .out_tail_node(out_tail_node), .out_tail_valid(out_tail_valid),
    .out_entry_count(out_entry_count)
  );

  doubly_linked_list_checker #(.NODES(POOL)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_node(in_node), .in_anchor(in_anchor),
    .in_anchor_null(in_anchor_null),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_head_node(out_head_node), .out_head_valid(out_head_valid),
    .out_tail_node(out_tail_node), .out_tail_valid(out_tail_valid),
    .out_entry_count(out_entry_count),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  function automatic logic [NODE_W-1:0] pick_free();
    logic [NODE_W-1:0] n;
    do n = NODE_W'($urandom_range(0, POOL - 1)); while (on_list[n]);
    return n;
  endfunction

  function automatic logic [NODE_W-1:0] pick_listed();
    logic [NODE_W-1:0] n;
    do n = NODE_W'($urandom_range(0, POOL - 1)); while (!on_list[n]);
    return n;
  endfunction

  // A node that was linked once and has been deleted since.
  function automatic logic [NODE_W-1:0] pick_stale();
    logic [NODE_W-1:0] n;
    do n = NODE_W'($urandom_range(0, POOL - 1)); while (!seen[n] || on_list[n]);
    return n;
  endfunction

  // Offers one request word and holds it until taken. Valid stays high
  // between back-to-back words and only drops for an idle burst.
  task automatic offer_request(input logic [OP_W-1:0]   op,
                               input logic [NODE_W-1:0] node,
                               input logic [NODE_W-1:0] anchor,
                               input logic              anull);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_node        <= node;
    in_anchor      <= anchor;
    in_anchor_null <= anull;
    do @(posedge clk); while (!in_ready);

    if (op <= OP_INS_BEFORE) begin
      if (!seen[node]) begin
        seen[node] = 1'b1;
        seen_total++;
      end
      if (!on_list[node]) begin
        on_list[node] = 1'b1;
        listed++;
      end
    end else if (op == OP_DELETE && on_list[node]) begin
      on_list[node] = 1'b0;
      listed--;
    end
  endtask

  // One random request. Most are well formed against the stimulus view of
  // the list; a few name nodes wrongly or use reserved codes.
  task automatic random_request(input int unsigned insert_pct);
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] anchor;
    logic              anull;
    int unsigned       roll;
    bit                do_insert;
    roll      = $urandom_range(0, 99);
    do_insert = (roll < insert_pct);
    op        = OP_DELETE;
    node      = NODE_W'($urandom);
    anchor    = NODE_W'($urandom);
    anull     = 1'($urandom_range(0, 1));

    if (roll < 2) begin
      op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else if (roll < 5 && listed > 0) begin
      // Reinsert a linked node, anchor a node on itself, or delete a stale one.
      case ($urandom_range(0, 2))
        0: begin
          op     = OP_W'($urandom_range(OP_INS_FIRST, OP_INS_BEFORE));
          node   = pick_listed();
          anchor = pick_listed();
        end
        1: begin
          op     = OP_W'($urandom_range(OP_INS_AFTER, OP_INS_BEFORE));
          node   = pick_listed();
          anchor = node;
          anull  = 1'b0;
        end
        default: begin
          node = (seen_total > listed) ? pick_stale() : pick_listed();
        end
      endcase
    end else if (listed == POOL && do_insert) begin
      // Full pool: a reinsert pushes the count against its ceiling.
      op   = OP_W'($urandom_range(OP_INS_FIRST, OP_INS_LAST));
      node = pick_listed();
    end else if (listed == 0 && !do_insert && seen_total > 0 &&
                 $urandom_range(0, 3) == 0) begin
      // Empty list: deleting again holds the count at zero.
      node = pick_stale();
    end else if (do_insert || listed == 0) begin
      op   = OP_W'($urandom_range(OP_INS_FIRST, OP_INS_BEFORE));
      node = pick_free();
      if (op == OP_INS_AFTER || op == OP_INS_BEFORE) begin
        if (listed == 0 || $urandom_range(0, 7) == 0) begin
          anull = 1'b1;
        end else begin
          anull  = 1'b0;
          anchor = pick_listed();
        end
      end
    end else begin
      node = pick_listed();
    end
    offer_request(op, node, anchor, anull);
  endtask

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    wait (rst_n);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned pct;
    pct = 50;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    // Directed: null anchors, head, tail and middle cases, reserved codes,
    // delete on an empty list, self anchor and reinsertion.
    offer_request(OP_SPARE_LO, 8'hFF, 8'hFF, 1'b1);
    offer_request(OP_INS_AFTER, 8'd0, 8'hAA, 1'b1);
    offer_request(OP_INS_BEFORE, 8'd255, 8'h55, 1'b1);
    offer_request(OP_INS_FIRST, 8'd10, 8'd0, 1'b0);
    offer_request(OP_INS_LAST, 8'd20, 8'hFF, 1'b1);
    offer_request(OP_INS_AFTER, 8'd11, 8'd10, 1'b0);
    offer_request(OP_INS_AFTER, 8'd254, 8'd20, 1'b0);
    offer_request(OP_INS_BEFORE, 8'd1, 8'd10, 1'b0);
    offer_request(OP_INS_BEFORE, 8'd128, 8'd255, 1'b0);
    offer_request(OP_DELETE, 8'd1, 8'd0, 1'b0);
    offer_request(OP_DELETE, 8'd254, 8'hFF, 1'b1);
    offer_request(OP_DELETE, 8'd0, 8'd0, 1'b0);
    offer_request(OP_W'(OP_SPARE_LO + 1), 8'hFF, 8'd0, 1'b0);
    offer_request(OP_SPARE_HI, 8'hFF, 8'hFF, 1'b1);
    offer_request(OP_DELETE, 8'd10, 8'd0, 1'b0);
    offer_request(OP_DELETE, 8'd11, 8'd0, 1'b0);
    offer_request(OP_DELETE, 8'd128, 8'd0, 1'b0);
    offer_request(OP_DELETE, 8'd255, 8'd0, 1'b0);
    offer_request(OP_DELETE, 8'd20, 8'd0, 1'b0);
    offer_request(OP_DELETE, 8'd20, 8'd0, 1'b0);
    offer_request(OP_INS_FIRST, 8'd7, 8'd0, 1'b0);
    offer_request(OP_INS_AFTER, 8'd7, 8'd7, 1'b0);
    offer_request(OP_INS_FIRST, 8'd7, 8'd0, 1'b0);
    offer_request(OP_DELETE, 8'd7, 8'd0, 1'b0);

    // Random: fill the pool, drain it, then mixed traffic. Idling is
    // switched per stretch and turned off for the last stretch.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (i >= RANDOM_WORDS - CALM_WORDS) idle_on = 1'b0;
      if (i == 200) hold_req = 1'b1;
      if (i < 400) pct = 90;
      else if (i < 800) pct = 10;
      else if (i % 50 == 0) pct = $urandom_range(20, 80);
      random_request(pct);
    end
    in_valid <= 1'b0;

    // Let the checker see the last request, drain the remaining results,
    // then allow time for stragglers.
    @(posedge clk);
    wait (outstanding == 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
